### rtl/core/ptsd_pkg.sv
// Shared types and constants for the point-to-triangle squared distance block.
package ptsd_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Nearest feature of the triangle.
  typedef enum logic [2:0] {
    RGN_V0  = 3'd0,
    RGN_V1  = 3'd1,
    RGN_V2  = 3'd2,
    RGN_E12 = 3'd3,
    RGN_E20 = 3'd4,
    RGN_E01 = 3'd5,
    RGN_INT = 3'd6
  } region_t;

  // How the final distance is formed.
  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_INT    = 2'd2
  } kind_t;

  typedef struct packed {
    region_t region;
    logic    no_region;
    logic    need_div;
  } tag_t;

endpackage

### rtl/core/point_triangle_sq_distance_top.sv
// Point-to-triangle squared distance: front-end arithmetic pipeline and divider.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | in_tdata: 12 coordinates, point then vertices 0..2
//  out_    | out | out_tvalid/out_tready | out_tdata: sq_distance; out_tuser: region, no_region
//
// One beat is taken per cycle while no full stage is stalled. The pipeline has
// eight arithmetic stages, then one divider stage per quotient bit.
// Reset is synchronous and clears only the stage valid bits.
// Every stage holds its beat while the next one is full and stalled; empty stages fill up.
module point_triangle_sq_distance_top #(
  parameter int COORD_BITS = ptsd_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // point_x, point_y, point_z, vert0_x..z, vert1_x..z, vert2_x..z from bit 0, zero pad
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]          in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // sq_distance from bit 0, zero pad
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0]         out_tdata,
  // region [2:0], no_region [3]
  output logic [3:0]                                  out_tuser
);

  localparam int C      = COORD_BITS;
  localparam int D      = C + 1;
  localparam int PW     = 2 * D;
  localparam int DW     = PW + 2;
  localparam int NW     = PW + 1;
  localparam int XW     = 2 * NW;
  localparam int SW     = XW + 2;
  localparam int ESW    = DW - 1;
  localparam int AMW    = NW + D + 1;
  localparam int AL     = (AMW + 1) / 2;
  localparam int AU     = AMW - AL;
  localparam int DIST_W = 2 * C + 2;
  localparam int NUM_W  = (2 * AMW > 2 * DW) ? 2 * AMW : 2 * DW;
  localparam int DEN_W  = 2 * NW;
  localparam int OUT_W  = ((DIST_W + 7) / 8) * 8;
  localparam int NF     = 8;

  // Vectors: 0 p-v0, 1 p-v1, 2 p-v2, 3 v1-v0, 4 v2-v1, 5 v0-v2.
  // Dots: 0 d0p20, 1 d0p01, 2 d1p01, 3 d1p12, 4 d2p12, 5 d2p20, 6..11 squared lengths.
  localparam int DOT_A [12] = '{0, 0, 1, 1, 2, 2, 0, 1, 2, 3, 4, 5};
  localparam int DOT_B [12] = '{5, 3, 3, 4, 4, 5, 0, 1, 2, 3, 4, 5};
  // Crosses: normal, c01, c12, c20.
  localparam int CRS_A [4]  = '{5, 3, 4, 5};
  localparam int CRS_B [4]  = '{3, 0, 1, 2};

  logic f_v_r [NF];
  logic adv   [NF+1];
  logic div_in_ready;

  assign adv[NF] = div_in_ready;
  for (genvar k = 0; k < NF; k++) begin : g_adv
    assign adv[k] = !f_v_r[k] || adv[k+1];
  end
  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NF; k++) f_v_r[k] <= 1'b0;
    end else begin
      if (adv[0]) f_v_r[0] <= in_tvalid;
      for (int k = 1; k < NF; k++) begin
        if (adv[k]) f_v_r[k] <= f_v_r[k-1];
      end
    end
  end

  // Stage 0: coordinate differences.
  logic signed [C-1:0] crd [4][3];
  logic signed [D-1:0] f0_vec_nxt [6][3], f0_vec_r [6][3];

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 3; i++) crd[m][i] = $signed(in_tdata[(3*m+i)*C +: C]);
    end
    for (int i = 0; i < 3; i++) begin
      f0_vec_nxt[0][i] = D'(crd[0][i]) - D'(crd[1][i]);
      f0_vec_nxt[1][i] = D'(crd[0][i]) - D'(crd[2][i]);
      f0_vec_nxt[2][i] = D'(crd[0][i]) - D'(crd[3][i]);
      f0_vec_nxt[3][i] = D'(crd[2][i]) - D'(crd[1][i]);
      f0_vec_nxt[4][i] = D'(crd[3][i]) - D'(crd[2][i]);
      f0_vec_nxt[5][i] = D'(crd[1][i]) - D'(crd[3][i]);
    end
  end

  // Stage 1: element products of dots and crosses.
  logic signed [PW-1:0] f1_dp_nxt [12][3], f1_dp_r [12][3];
  logic signed [PW-1:0] f1_cp_nxt [4][3][2], f1_cp_r [4][3][2];
  logic signed [D-1:0]  f1_vp0_r [3];

  always_comb begin
    for (int j = 0; j < 12; j++) begin
      for (int i = 0; i < 3; i++) begin
        f1_dp_nxt[j][i] = PW'(f0_vec_r[DOT_A[j]][i]) * PW'(f0_vec_r[DOT_B[j]][i]);
      end
    end
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) begin
        f1_cp_nxt[j][i][0] = PW'(f0_vec_r[CRS_A[j]][(i+1)%3]) *
                             PW'(f0_vec_r[CRS_B[j]][(i+2)%3]);
        f1_cp_nxt[j][i][1] = PW'(f0_vec_r[CRS_A[j]][(i+2)%3]) *
                             PW'(f0_vec_r[CRS_B[j]][(i+1)%3]);
      end
    end
  end

  // Stage 2: dot sums and cross components.
  logic signed [DW-1:0] f2_dot_nxt [12], f2_dot_r [12];
  logic signed [NW-1:0] f2_crs_nxt [4][3], f2_crs_r [4][3];
  logic signed [D-1:0]  f2_vp0_r [3];

  always_comb begin
    for (int j = 0; j < 12; j++) begin
      f2_dot_nxt[j] = DW'(f1_dp_r[j][0]) + DW'(f1_dp_r[j][1]) + DW'(f1_dp_r[j][2]);
    end
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) f2_crs_nxt[j][i] = NW'(f1_cp_r[j][i][0]) - NW'(f1_cp_r[j][i][1]);
    end
  end

  // Stage 3: products against the normal.
  logic signed [XW-1:0] f3_xp_nxt [5][3], f3_xp_r [5][3];
  logic signed [DW-1:0] f3_dot_r [12];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) f3_xp_nxt[j][i] = XW'(f2_crs_r[0][i]) * XW'(f2_crs_r[j+1][i]);
      f3_xp_nxt[3][i] = XW'(f2_crs_r[0][i]) * XW'(f2_crs_r[0][i]);
      f3_xp_nxt[4][i] = XW'(f2_crs_r[0][i]) * XW'(f2_vp0_r[i]);
    end
  end

  // Stage 4: edge side tests, n.n and n.(p-v0).
  logic signed [SW-1:0] f4_sd_nxt [5], f4_sd_r [5];
  logic signed [DW-1:0] f4_dot_r [12];

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      f4_sd_nxt[j] = SW'(f3_xp_r[j][0]) + SW'(f3_xp_r[j][1]) + SW'(f3_xp_r[j][2]);
    end
  end

  // Stage 5: region decision and operand selection.
  ptsd_pkg::kind_t   f5_kind_nxt, f5_kind_r;
  ptsd_pkg::region_t f5_region_nxt, f5_region_r;
  logic              f5_bad_nxt, f5_bad_r;
  logic [DIST_W-1:0] f5_direct_nxt, f5_direct_r;
  logic [ESW-1:0]    f5_sq_nxt, f5_sq_r, f5_len2_nxt, f5_len2_r;
  logic signed [DW-1:0] f5_prj_nxt, f5_prj_r;
  logic [AU-1:0]     f5_ahi_r;
  logic [AL-1:0]     f5_alo_r;
  logic [DEN_W-1:0]  f5_nn_r;
  logic              dge [12], dle [12], sge [3], sle [3];
  logic              is_edge, apab_le;
  logic signed [DW-1:0] ap_sq, sel_sq, sel_len2;
  logic signed [SW-1:0] amag;

  always_comb begin
    for (int j = 0; j < 12; j++) begin
      dge[j] = !f4_dot_r[j][DW-1];
      dle[j] = f4_dot_r[j][DW-1] || (f4_dot_r[j] == '0);
    end
    for (int j = 0; j < 3; j++) begin
      sge[j] = !f4_sd_r[j][SW-1];
      sle[j] = f4_sd_r[j][SW-1] || (f4_sd_r[j] == '0);
    end
    f5_kind_nxt   = ptsd_pkg::KIND_DIRECT;
    f5_region_nxt = ptsd_pkg::RGN_V0;
    f5_bad_nxt    = 1'b0;
    f5_direct_nxt = '0;
    is_edge       = 1'b0;
    apab_le       = 1'b0;
    f5_prj_nxt    = '0;
    ap_sq         = '0;
    sel_sq        = '0;
    sel_len2      = '0;
    if (dge[0] && dle[1]) begin
      f5_direct_nxt = f4_dot_r[6][DIST_W-1:0];
    end else if (dge[2] && dle[3]) begin
      f5_region_nxt = ptsd_pkg::RGN_V1;
      f5_direct_nxt = f4_dot_r[7][DIST_W-1:0];
    end else if (dge[4] && dle[5]) begin
      f5_region_nxt = ptsd_pkg::RGN_V2;
      f5_direct_nxt = f4_dot_r[8][DIST_W-1:0];
    end else if (sle[0] && dge[1] && dle[2]) begin
      f5_region_nxt = ptsd_pkg::RGN_E01;
      is_edge = 1'b1;  apab_le = dle[1];  f5_prj_nxt = f4_dot_r[2];
      ap_sq = f4_dot_r[6];  sel_sq = f4_dot_r[7];  sel_len2 = f4_dot_r[9];
    end else if (sle[1] && dge[3] && dle[4]) begin
      f5_region_nxt = ptsd_pkg::RGN_E12;
      is_edge = 1'b1;  apab_le = dle[3];  f5_prj_nxt = f4_dot_r[4];
      ap_sq = f4_dot_r[7];  sel_sq = f4_dot_r[8];  sel_len2 = f4_dot_r[10];
    end else if (sle[2] && dge[5] && dle[0]) begin
      f5_region_nxt = ptsd_pkg::RGN_E20;
      is_edge = 1'b1;  apab_le = dle[5];  f5_prj_nxt = f4_dot_r[0];
      ap_sq = f4_dot_r[8];  sel_sq = f4_dot_r[6];  sel_len2 = f4_dot_r[11];
    end else if (sge[0] && sge[1] && sge[2]) begin
      // A zero normal means the triangle is degenerate.
      if (f4_sd_r[3] == '0) begin
        f5_bad_nxt = 1'b1;
      end else begin
        f5_region_nxt = ptsd_pkg::RGN_INT;
        f5_kind_nxt   = ptsd_pkg::KIND_INT;
      end
    end else begin
      f5_bad_nxt = 1'b1;
    end
    // The projection falls before the start or past the end of the segment, or else between them and is divided out.
    if (is_edge) begin
      if (apab_le) begin
        f5_direct_nxt = ap_sq[DIST_W-1:0];
      end else if (!f5_prj_nxt[DW-1]) begin
        f5_direct_nxt = sel_sq[DIST_W-1:0];
      end else begin
        f5_kind_nxt = ptsd_pkg::KIND_EDGE;
      end
    end
    if (f5_bad_nxt) begin
      f5_region_nxt = ptsd_pkg::RGN_V0;
      f5_direct_nxt = '0;
    end
    f5_sq_nxt   = sel_sq[ESW-1:0];
    f5_len2_nxt = sel_len2[ESW-1:0];
    amag        = f4_sd_r[4][SW-1] ? -f4_sd_r[4] : f4_sd_r[4];
  end

  // Stage 6: the numerator products, with a*a cut into halves.
  ptsd_pkg::kind_t   f6_kind_r;
  ptsd_pkg::region_t f6_region_r;
  logic              f6_bad_r;
  logic [DIST_W-1:0] f6_direct_r;
  logic [ESW-1:0]    f6_len2_r;
  logic [DEN_W-1:0]  f6_nn_r;
  logic [2*ESW-1:0]  f6_sl_nxt, f6_sl_r;
  logic signed [2*DW-1:0] f6_pp_nxt;
  logic [2*DW-1:0]   f6_pp_r;
  logic [2*AU-1:0]   f6_hh_nxt, f6_hh_r;
  logic [AU+AL-1:0]  f6_hl_nxt, f6_hl_r;
  logic [2*AL-1:0]   f6_ll_nxt, f6_ll_r;

  always_comb begin
    f6_sl_nxt = (2*ESW)'(f5_sq_r) * (2*ESW)'(f5_len2_r);
    f6_pp_nxt = (2*DW)'(f5_prj_r) * (2*DW)'(f5_prj_r);
    f6_hh_nxt = (2*AU)'(f5_ahi_r) * (2*AU)'(f5_ahi_r);
    f6_hl_nxt = (AU+AL)'(f5_ahi_r) * (AU+AL)'(f5_alo_r);
    f6_ll_nxt = (2*AL)'(f5_alo_r) * (2*AL)'(f5_alo_r);
  end

  // Stage 7: numerator, divisor and the decision to divide.
  logic [NUM_W-1:0]  f7_num_nxt, f7_num_r;
  logic [DEN_W-1:0]  f7_den_nxt, f7_den_r;
  logic [DIST_W-1:0] f7_direct_nxt, f7_direct_r;
  ptsd_pkg::tag_t    f7_tag_nxt, f7_tag_r;
  logic [NUM_W:0]    ediff;
  logic [NUM_W-1:0]  asq;

  always_comb begin
    ediff = (NUM_W+1)'(f6_sl_r) - (NUM_W+1)'(f6_pp_r);
    asq   = (NUM_W'(f6_hh_r) << (2 * AL)) + (NUM_W'(f6_hl_r) << (AL + 1)) + NUM_W'(f6_ll_r);
    f7_tag_nxt.region    = f6_region_r;
    f7_tag_nxt.no_region = f6_bad_r;
    f7_tag_nxt.need_div  = 1'b0;
    f7_direct_nxt        = f6_direct_r;
    f7_num_nxt           = ediff[NUM_W-1:0];
    f7_den_nxt           = DEN_W'(f6_len2_r);
    case (f6_kind_r)
      ptsd_pkg::KIND_EDGE: begin
        // A distance that comes out zero or negative is clamped to zero.
        f7_direct_nxt       = '0;
        f7_tag_nxt.need_div = !ediff[NUM_W] && (ediff != '0) && (f6_len2_r != '0);
      end
      ptsd_pkg::KIND_INT: begin
        f7_num_nxt          = asq;
        f7_den_nxt          = f6_nn_r;
        f7_tag_nxt.need_div = 1'b1;
      end
      default: begin
        f7_tag_nxt.need_div = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) f0_vec_r <= f0_vec_nxt;
    if (adv[1]) begin
      f1_dp_r  <= f1_dp_nxt;
      f1_cp_r  <= f1_cp_nxt;
      f1_vp0_r <= f0_vec_r[0];
    end
    if (adv[2]) begin
      f2_dot_r <= f2_dot_nxt;
      f2_crs_r <= f2_crs_nxt;
      f2_vp0_r <= f1_vp0_r;
    end
    if (adv[3]) begin
      f3_xp_r  <= f3_xp_nxt;
      f3_dot_r <= f2_dot_r;
    end
    if (adv[4]) begin
      f4_sd_r  <= f4_sd_nxt;
      f4_dot_r <= f3_dot_r;
    end
    if (adv[5]) begin
      f5_kind_r   <= f5_kind_nxt;
      f5_region_r <= f5_region_nxt;
      f5_bad_r    <= f5_bad_nxt;
      f5_direct_r <= f5_direct_nxt;
      f5_sq_r     <= f5_sq_nxt;
      f5_len2_r   <= f5_len2_nxt;
      f5_prj_r    <= f5_prj_nxt;
      f5_ahi_r    <= amag[AMW-1:AL];
      f5_alo_r    <= amag[AL-1:0];
      f5_nn_r     <= f4_sd_r[3][DEN_W-1:0];
    end
    if (adv[6]) begin
      f6_kind_r   <= f5_kind_r;
      f6_region_r <= f5_region_r;
      f6_bad_r    <= f5_bad_r;
      f6_direct_r <= f5_direct_r;
      f6_len2_r   <= f5_len2_r;
      f6_nn_r     <= f5_nn_r;
      f6_sl_r     <= f6_sl_nxt;
      f6_pp_r     <= f6_pp_nxt;
      f6_hh_r     <= f6_hh_nxt;
      f6_hl_r     <= f6_hl_nxt;
      f6_ll_r     <= f6_ll_nxt;
    end
    if (adv[7]) begin
      f7_num_r    <= f7_num_nxt;
      f7_den_r    <= f7_den_nxt;
      f7_direct_r <= f7_direct_nxt;
      f7_tag_r    <= f7_tag_nxt;
    end
  end

  logic [DIST_W-1:0] div_quo;
  ptsd_pkg::tag_t    div_tag;

  ptsd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (DIST_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_v_r[NF-1]),
    .in_ready  (div_in_ready),
    .in_num    (f7_num_r),
    .in_den    (f7_den_r),
    .in_direct (f7_direct_r),
    .in_tag    (f7_tag_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_quo   (div_quo),
    .out_tag   (div_tag)
  );

  assign out_tdata = OUT_W'(div_quo);
  assign out_tuser = {div_tag.no_region, div_tag.region};

  a_edge_region: assert property (@(posedge clk) disable iff (!rst_n)
      f_v_r[5] && f5_kind_r == ptsd_pkg::KIND_EDGE |->
      f5_region_r == ptsd_pkg::RGN_E01 || f5_region_r == ptsd_pkg::RGN_E12 ||
      f5_region_r == ptsd_pkg::RGN_E20)
    else $error("edge projection tagged with a non-edge region");

  a_int_nn: assert property (@(posedge clk) disable iff (!rst_n)
      f_v_r[5] && f5_kind_r == ptsd_pkg::KIND_INT |-> f5_nn_r != '0 && !f5_bad_r)
    else $error("interior case with zero normal");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
      f_v_r[NF-1] && f7_tag_r.need_div |-> f7_den_r != '0 && !f7_tag_r.no_region)
    else $error("division requested with zero divisor");

endmodule

### rtl/core/ptsd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a pass-through result.
module ptsd_div #(
  parameter int NUM_W = 106,
  parameter int DEN_W = 70,
  parameter int Q_W   = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [NUM_W-1:0]   in_num,
  input  logic [DEN_W-1:0]   in_den,
  input  logic [Q_W-1:0]     in_direct,
  input  ptsd_pkg::tag_t     in_tag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [Q_W-1:0]     out_quo,
  output ptsd_pkg::tag_t     out_tag
);

  localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [RW-1:0]    rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  ptsd_pkg::tag_t   tag_r [Q_W];
  logic             v_r   [Q_W];
  logic             adv   [Q_W+1];

  assign adv[Q_W] = out_ready;

  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    logic [RW-1:0]    rem_in, dsh, rem_nxt;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in, quo_nxt;
    ptsd_pkg::tag_t   tag_in;
    logic             v_in, ge;

    // A stage can take a new beat when it is empty or its own beat moves on.
    assign adv[k] = !v_r[k] || adv[k+1];

    if (k == 0) begin : g_first
      assign rem_in = RW'(in_num);
      assign den_in = in_den;
      assign quo_in = in_tag.need_div ? '0 : in_direct;
      assign tag_in = in_tag;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign tag_in = tag_r[k-1];
      assign v_in   = v_r[k-1];
    end

    assign dsh     = RW'(den_in) << (Q_W - 1 - k);
    assign ge      = tag_in.need_div && (rem_in >= dsh);
    assign rem_nxt = ge ? rem_in - dsh : rem_in;
    assign quo_nxt = ge ? (quo_in | (Q_W'(1) << (Q_W - 1 - k))) : quo_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
      v_r[0] && tag_r[0].need_div |-> rem_r[0] < (RW'(den_r[0]) << (Q_W - 1)))
    else $error("quotient would overflow its width");

  a_rem_final: assert property (@(posedge clk) disable iff (!rst_n)
      v_r[Q_W-1] && tag_r[Q_W-1].need_div |-> rem_r[Q_W-1] < RW'(den_r[Q_W-1]))
    else $error("final remainder not below divisor");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_tag.no_region |-> out_quo == '0 && !out_tag.need_div)
    else $error("no-region beat carries a distance");

endmodule

### verif/point_triangle_sq_distance_top_tb.sv
// Self-checking testbench for the point-to-triangle squared distance block.
module point_triangle_sq_distance_top_tb;

  localparam int CB = 16;
  localparam int DW = 2 * CB + 2;
  localparam int IN_W = ((12 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((DW + 7) / 8) * 8;
  localparam int LATENCY = 8 + DW;

  typedef struct {
    logic [DW-1:0]       sqd;
    ptsd_pkg::region_t   rgn;
    logic                bad;
  } dist_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [3:0] out_tuser;

  point_triangle_sq_distance_top #(.COORD_BITS(CB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  logic [IN_W-1:0] pending_q[$];
  dist_res_t expected_q[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int rgn_seen[8];
  int bad_seen = 0;
  bit calm = 0;
  bit hold_long = 0;
  int src_gap = 0;
  int sink_gap = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Vector helpers on signed 64-bit values; products fit in 128 bits.
  function automatic longint dot3(longint a[3], longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic logic signed [127:0] wdot3(longint a[3], longint b[3]);
    logic signed [127:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s += 128'(signed'(a[i])) * 128'(signed'(b[i]));
    return s;
  endfunction

  function automatic void cross3(longint a[3], longint b[3], output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic int sgn(logic signed [127:0] v);
    return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
  endfunction

  function automatic logic [63:0] segment_sq(longint p[3], longint a[3], longint b[3]);
    longint ap[3], ab[3], bp[3];
    longint prj, sq, len2;
    logic signed [127:0] num;
    for (int i = 0; i < 3; i++) begin
      ap[i] = p[i] - a[i];
      ab[i] = b[i] - a[i];
      bp[i] = p[i] - b[i];
    end
    if (dot3(ap, ab) <= 0) return dot3(ap, ap);
    prj = dot3(bp, ab);
    sq = dot3(bp, bp);
    if (prj >= 0) return sq;
    len2 = dot3(ab, ab);
    num = 128'(signed'(sq)) * 128'(signed'(len2)) - 128'(signed'(prj)) * 128'(signed'(prj));
    if (num <= 0 || len2 <= 0) return '0;
    return 64'(num / 128'(signed'(len2)));
  endfunction

  function automatic dist_res_t nearest_feature(logic [IN_W-1:0] d);
    longint pt[3], q0[3], q1[3], q2[3];
    longint v0p[3], v20[3], v01[3], v1p[3], v12[3], v2p[3];
    longint nrm[3], c01[3], c12[3], c20[3];
    longint d0p20, d0p01, d1p01, d1p12, d2p12, d2p20;
    int s01, s12, s20;
    logic signed [127:0] nn, av;
    logic [63:0] sq_val;
    dist_res_t r;
    for (int i = 0; i < 3; i++) begin
      pt[i] = longint'($signed(d[i*CB +: CB]));
      q0[i] = longint'($signed(d[(3+i)*CB +: CB]));
      q1[i] = longint'($signed(d[(6+i)*CB +: CB]));
      q2[i] = longint'($signed(d[(9+i)*CB +: CB]));
    end
    for (int i = 0; i < 3; i++) begin
      v0p[i] = pt[i] - q0[i];
      v20[i] = q0[i] - q2[i];
      v01[i] = q1[i] - q0[i];
      v1p[i] = pt[i] - q1[i];
      v12[i] = q2[i] - q1[i];
      v2p[i] = pt[i] - q2[i];
    end
    d0p20 = dot3(v0p, v20);
    d0p01 = dot3(v0p, v01);
    d1p01 = dot3(v1p, v01);
    d1p12 = dot3(v1p, v12);
    d2p12 = dot3(v2p, v12);
    d2p20 = dot3(v2p, v20);
    cross3(v20, v01, nrm);
    cross3(v01, v0p, c01);
    cross3(v12, v1p, c12);
    cross3(v20, v2p, c20);
    s01 = sgn(wdot3(nrm, c01));
    s12 = sgn(wdot3(nrm, c12));
    s20 = sgn(wdot3(nrm, c20));
    r.bad = 1'b0;
    r.rgn = ptsd_pkg::RGN_V0;
    sq_val = '0;
    if (d0p20 >= 0 && d0p01 <= 0) begin
      r.rgn = ptsd_pkg::RGN_V0; sq_val = dot3(v0p, v0p);
    end else if (d1p01 >= 0 && d1p12 <= 0) begin
      r.rgn = ptsd_pkg::RGN_V1; sq_val = dot3(v1p, v1p);
    end else if (d2p12 >= 0 && d2p20 <= 0) begin
      r.rgn = ptsd_pkg::RGN_V2; sq_val = dot3(v2p, v2p);
    end else if (s01 <= 0 && d0p01 >= 0 && d1p01 <= 0) begin
      r.rgn = ptsd_pkg::RGN_E01; sq_val = segment_sq(pt, q0, q1);
    end else if (s12 <= 0 && d1p12 >= 0 && d2p12 <= 0) begin
      r.rgn = ptsd_pkg::RGN_E12; sq_val = segment_sq(pt, q1, q2);
    end else if (s20 <= 0 && d2p20 >= 0 && d0p20 <= 0) begin
      r.rgn = ptsd_pkg::RGN_E20; sq_val = segment_sq(pt, q2, q0);
    end else if (s01 >= 0 && s12 >= 0 && s20 >= 0) begin
      nn = wdot3(nrm, nrm);
      if (nn == 0) r.bad = 1'b1;
      else begin
        // a*a can pass 2^100, so the square and the division run at 256 bits.
        av = wdot3(nrm, v0p);
        r.rgn = ptsd_pkg::RGN_INT;
        sq_val = 64'(({{128{av[127]}}, av} * {{128{av[127]}}, av}) / {128'd0, nn});
      end
    end else r.bad = 1'b1;
    if (r.bad) begin
      sq_val = '0;
      r.rgn = ptsd_pkg::RGN_V0;
    end
    r.sqd = sq_val[DW-1:0];
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_tri(int c[12]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 12; i++) d[i*CB +: CB] = CB'(c[i]);
    return d;
  endfunction

  function automatic void queue_tri(int c[12]);
    pending_q.insert(pending_q.size(), pack_tri(c));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Sender: holds a beat until accepted, gaps only between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_q.insert(expected_q.size(), nearest_feature(in_tdata));
        beats_in++;
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_tdata <= pending_q.pop_front();
        in_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 15);
      end else in_tvalid <= 1'b0;
    end
  end

  // Receiver with random stall bursts and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) report_mismatch("unexpected beat", beats_out, -1);
        else begin
          dist_res_t e;
          e = expected_q.pop_front();
          if (out_tdata[DW-1:0] !== e.sqd)
            report_mismatch("sq_distance", out_tdata[DW-1:0], e.sqd);
          if (out_tuser[2:0] !== e.rgn) report_mismatch("region", out_tuser[2:0], e.rgn);
          if (out_tuser[3] !== e.bad) report_mismatch("no_region", out_tuser[3], e.bad);
          if (out_tdata[OUT_W-1:DW] !== '0) report_mismatch("tdata pad", out_tdata, 0);
          rgn_seen[e.rgn]++;
          bad_seen += e.bad;
        end
        beats_out++;
      end
      if (hold_long) out_tready <= 1'b0;
      else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 15);
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering beats.
  initial begin
    @(posedge rst_n);
    repeat (20) @(posedge clk);
    hold_long = 1;
    repeat (200) @(posedge clk);
    hold_long = 0;
  end

  function automatic int rnd_coord(int mode);
    case (mode)
      0: return int'($urandom_range(0, (1 << CB) - 1)) - (1 << (CB - 1));
      1: return int'($urandom_range(0, 2047)) - 1024;
      default: return int'($urandom_range(0, 63)) - 32;
    endcase
  endfunction

  initial begin
    int c[12];
    int mx, mn;
    int mode;
    mx = (1 << (CB - 1)) - 1;
    mn = -(1 << (CB - 1));
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // Directed: triangle v0=(0,0,0) v1=(256,0,0) v2=(0,256,0), points per region.
    c = '{default: 0};
    c[6] = 256; c[10] = 256;
    c[0] = -100; c[1] = -100; c[2] = 50; queue_tri(c); // near v0
    c[0] = 400; c[1] = -10; c[2] = 0; queue_tri(c);    // near v1
    c[0] = -10; c[1] = 400; c[2] = 9; queue_tri(c);    // near v2
    c[0] = 100; c[1] = -50; c[2] = 3; queue_tri(c);    // edge v0v1
    c[0] = 200; c[1] = 200; c[2] = -7; queue_tri(c);   // edge v1v2
    c[0] = -60; c[1] = 100; c[2] = 1; queue_tri(c);    // edge v2v0
    c[0] = 60; c[1] = 60; c[2] = 77; queue_tri(c);     // interior
    c[0] = 60; c[1] = 60; c[2] = 0; queue_tri(c);      // in plane
    // Degenerate triangles: all vertices equal, and collinear.
    c = '{default: 0};
    c[3] = 5; c[6] = 5; c[9] = 5; c[0] = 7; queue_tri(c);
    c = '{default: 0};
    c[6] = 100; c[9] = 200; c[1] = 30; queue_tri(c);
    c = '{default: 0};
    queue_tri(c);
    c = '{default: mx}; queue_tri(c);
    c = '{default: mn}; queue_tri(c);
    // Largest spread: extremes mixed between point and vertices.
    c = '{default: mn}; c[0] = mx; c[1] = mx; c[2] = mx; queue_tri(c);
    c = '{default: mx}; c[3] = mn; c[7] = mn; c[11] = mn; queue_tri(c);
    c = '{default: mn}; c[6] = mx; c[10] = mx; c[2] = mx; queue_tri(c);
    c = '{default: mn}; c[6] = mx; c[10] = mx; c[0] = mx; c[1] = mx;
    queue_tri(c);

    // Enough beats to fill the block during the receiver hold-off.
    for (int n = 0; n < 120; n++) begin
      for (int i = 0; i < 12; i++) c[i] = rnd_coord(1);
      queue_tri(c);
    end

    for (int n = 0; n < 1800; n++) begin
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 12; i++) c[i] = rnd_coord(mode);
      if ($urandom_range(0, 19) == 0) c[3 * $urandom_range(2, 3) + $urandom_range(0, 2)] =
        c[3 + $urandom_range(0, 2)];
      if ($urandom_range(0, 29) == 0) c[$urandom_range(0, 11)] = $urandom_range(0, 1) ? mx : mn;
      queue_tri(c);
      if (n == 1500) begin
        while (pending_q.size() > 0) @(posedge clk);
        calm = 1;
      end
    end
    while (pending_q.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d beats in, %0d out; regions v0/v1/v2 %0d/%0d/%0d, edges %0d/%0d/%0d,",
             beats_in, beats_out, rgn_seen[0], rgn_seen[1], rgn_seen[2], rgn_seen[5],
             rgn_seen[3], rgn_seen[4]);
    $display("interior %0d, no-region %0d, with random stalls and one long output hold-off.",
             rgn_seen[6], bad_seen);
    if (errors == 0) $display("point_triangle_sq_distance_top_tb OK");
    else $display("point_triangle_sq_distance_top_tb NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("point_triangle_sq_distance_top_tb NOT OK");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ptsd_pkg.sv
rtl/core/ptsd_div.sv
rtl/core/point_triangle_sq_distance_top.sv
verif/point_triangle_sq_distance_top_tb.sv
